// ----- rtl/wssc_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted subsequence support counter package
// Shared widths, register indexes and the queue entry layout.
// ----------------------------------------------------------------------------
package wssc_pkg;

    // Default sizing of the pattern store.
    localparam int MAX_PATTERN_DEF = 8;
    localparam int ITEM_BITS_DEF   = 16;

    // Fixed field widths.
    localparam int SLOT_BITS   = 16;
    localparam int POS_W       = 4;
    localparam int WEIGHT_W    = 20;
    localparam int SUM_W       = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Depth of the queue between front and back, a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Reset value of the low-weight limit.
    localparam logic [WEIGHT_W-1:0] LIMIT_RESET = 20'd10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_APPROX       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT        = 3'd4;

    // Scalar configuration seen by the front.
    typedef struct packed {
        logic [POS_W-1:0]    eff_len;
        logic                approx;
        logic [WEIGHT_W-1:0] limit;
    } ctrl_t;

    // One classified word travelling from front to back.
    typedef struct packed {
        logic                db_start;
        logic                seq_end;
        logic                contained;
        logic                counted;
        logic [WEIGHT_W-1:0] weight;
    } entry_t;

endpackage

// ----- rtl/weighted_subsequence_support_counter_unit.sv -----
// ----------------------------------------------------------------------------
// Weighted subsequence support counter
// Counts the weighted support of a fixed itemset pattern over streamed
// database sequences.
// ----------------------------------------------------------------------------
// Usage:
// Database sequences arrive on the s_ group, one itemset per word, with
// tlast on the last itemset of a sequence and tuser set on the first word
// of a database, which clears the total. For each word carrying tlast the
// m_ group returns one word with the containment flag, the counted flag and
// the running support total, saturating at the 32-bit maximum.
// The cfg channel writes the pattern halves, length, mode and limit; it is
// always ready; the user must write it only while the block is idle, which
// is not enforced. Throughput is one word per cycle while s_tready is high:
// the front matches and classifies in the accept cycle, and the back retires
// one queue entry per cycle unless stalled. Results pass the queue, then the
// result register. When the receiver stalls, the result register holds and
// the four-entry queue absorbs further words; s_tready drops only when the
// queue is full. Reset clears the match position, total, queue and
// configuration; the low-weight limit returns to ten.
// ----------------------------------------------------------------------------
module weighted_subsequence_support_counter_unit #(
    parameter int MAX_PATTERN = wssc_pkg::MAX_PATTERN_DEF,
    parameter int ITEM_BITS   = wssc_pkg::ITEM_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [wssc_pkg::IN_TDATA_W-1:0]       s_tdata,   // itemset[15:0], weight[35:16]
    input  logic                                  s_tlast,   // sequence_end
    input  logic                                  s_tuser,   // database_start
    // Result stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [wssc_pkg::OUT_TDATA_W-1:0]      m_tdata,   // contained[0], counted[1],
                                                             // support_total[33:2]
    // Configuration writes.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wssc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wssc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [MAX_PATTERN-1:0][ITEM_BITS-1:0] pattern;
    wssc_pkg::ctrl_t                       ctrl;
    wssc_pkg::entry_t                      push_entry;
    wssc_pkg::entry_t                      pop_entry;
    logic                                  push;
    logic                                  pop;
    logic                                  full;
    logic                                  empty;
    logic                                  accept;
    logic                                  res_contained;
    logic                                  res_counted;
    logic [wssc_pkg::SUM_W-1:0]            res_total;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign accept    = s_tvalid && !full;

    wssc_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .ITEM_BITS   (ITEM_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .pattern  (pattern),
        .ctrl     (ctrl)
    );

    wssc_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .ITEM_BITS   (ITEM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .itemset    (s_tdata[wssc_pkg::SLOT_BITS-1:0]),
        .weight     (s_tdata[wssc_pkg::SLOT_BITS +: wssc_pkg::WEIGHT_W]),
        .seq_end    (s_tlast),
        .db_start   (s_tuser),
        .pattern    (pattern),
        .ctrl       (ctrl),
        .push       (push),
        .push_entry (push_entry)
    );

    wssc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    wssc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .entry         (pop_entry),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_contained (res_contained),
        .out_counted   (res_counted),
        .out_total     (res_total)
    );

    // Pack the result word, zero filled to whole bytes.
    assign m_tdata = {(wssc_pkg::OUT_TDATA_W - wssc_pkg::SUM_W - 2)'(0),
                      res_total, res_counted, res_contained};

endmodule

// ----- rtl/wssc_cfg.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the pattern itemsets, pattern length, mode and low-weight limit.
// ----------------------------------------------------------------------------
module wssc_cfg #(
    parameter int MAX_PATTERN = wssc_pkg::MAX_PATTERN_DEF,
    parameter int ITEM_BITS   = wssc_pkg::ITEM_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    wr_en,
    input  logic [wssc_pkg::CFG_IDX_W-1:0]          wr_index,
    input  logic [wssc_pkg::CFG_DATA_W-1:0]         wr_data,
    output logic [MAX_PATTERN-1:0][ITEM_BITS-1:0]   pattern,
    output wssc_pkg::ctrl_t                         ctrl
);

    localparam int HALF_SLOTS = wssc_pkg::CFG_DATA_W / wssc_pkg::SLOT_BITS;

    logic [MAX_PATTERN-1:0][ITEM_BITS-1:0] pattern_reg;
    logic [wssc_pkg::POS_W-1:0]            length_reg;
    logic                                  approx_reg;
    logic [wssc_pkg::WEIGHT_W-1:0]         limit_reg;

    // Register writes; each pattern half feeds four slots.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= '0;
            approx_reg  <= 1'b0;
            limit_reg   <= wssc_pkg::LIMIT_RESET;
        end
        else if (wr_en)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                if ((i < HALF_SLOTS && wr_index == wssc_pkg::REG_PATTERN_LOW) ||
                    (i >= HALF_SLOTS && wr_index == wssc_pkg::REG_PATTERN_HIGH))
                begin
                    pattern_reg[i] <= wr_data[(i % HALF_SLOTS) * wssc_pkg::SLOT_BITS +: ITEM_BITS];
                end
            end
            if (wr_index == wssc_pkg::REG_LENGTH)
            begin
                length_reg <= wr_data[wssc_pkg::POS_W-1:0];
            end
            if (wr_index == wssc_pkg::REG_APPROX)
            begin
                approx_reg <= wr_data[0];
            end
            if (wr_index == wssc_pkg::REG_LIMIT)
            begin
                limit_reg <= wr_data[wssc_pkg::WEIGHT_W-1:0];
            end
        end
    end

    // A length above the store size is clamped.
    always_comb
    begin
        if (length_reg > wssc_pkg::POS_W'(MAX_PATTERN))
        begin
            ctrl.eff_len = wssc_pkg::POS_W'(MAX_PATTERN);
        end
        else
        begin
            ctrl.eff_len = length_reg;
        end
        ctrl.approx = approx_reg;
        ctrl.limit  = limit_reg;
    end

    assign pattern = pattern_reg;

endmodule

// ----- rtl/wssc_front.sv -----
// ----------------------------------------------------------------------------
// Front end
// Tracks the greedy match position and classifies each accepted word.
// ----------------------------------------------------------------------------
module wssc_front #(
    parameter int MAX_PATTERN = wssc_pkg::MAX_PATTERN_DEF,
    parameter int ITEM_BITS   = wssc_pkg::ITEM_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    accept,
    input  logic [wssc_pkg::SLOT_BITS-1:0]          itemset,
    input  logic [wssc_pkg::WEIGHT_W-1:0]           weight,
    input  logic                                    seq_end,
    input  logic                                    db_start,
    input  logic [MAX_PATTERN-1:0][ITEM_BITS-1:0]   pattern,
    input  wssc_pkg::ctrl_t                         ctrl,
    output logic                                    push,
    output wssc_pkg::entry_t                        push_entry
);

    logic [wssc_pkg::POS_W-1:0] pos_reg;
    logic [wssc_pkg::POS_W-1:0] pos_adv;
    logic [wssc_pkg::POS_W-1:0] pos_next;
    logic [ITEM_BITS-1:0]       pat;
    logic [ITEM_BITS-1:0]       item;

    // Select the pattern itemset at the current position.
    always_comb
    begin
        pat = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (pos_reg == wssc_pkg::POS_W'(i))
            begin
                pat = pattern[i];
            end
        end
    end

    assign item = itemset[ITEM_BITS-1:0];

    // Advance when the itemset covers every pattern bit.
    always_comb
    begin
        pos_adv = pos_reg;
        if (pos_reg < ctrl.eff_len && (item & pat) == pat)
        begin
            pos_adv = pos_reg + 1'b1;
        end
        pos_next = seq_end ? '0 : pos_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    // Only words that touch the total go to the back.
    always_comb
    begin
        push                 = accept && (seq_end || db_start);
        push_entry.db_start  = db_start;
        push_entry.seq_end   = seq_end;
        push_entry.contained = (pos_adv >= ctrl.eff_len);
        push_entry.counted   = (pos_adv >= ctrl.eff_len) ||
                               (ctrl.approx && weight <= ctrl.limit);
        push_entry.weight    = weight;
    end

endmodule

// ----- rtl/wssc_queue.sv -----
// ----------------------------------------------------------------------------
// Entry queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module wssc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wssc_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output wssc_pkg::entry_t pop_entry,
    output logic             empty
);

    localparam int PTR_W = $clog2(wssc_pkg::QUEUE_DEPTH);

    wssc_pkg::entry_t  slot_reg [wssc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    assign full      = (count_reg == (PTR_W + 1)'(wssc_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/wssc_back.sv -----
// ----------------------------------------------------------------------------
// Back end
// Keeps the saturating support total and drives the result register.
// ----------------------------------------------------------------------------
module wssc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          empty,
    input  wssc_pkg::entry_t              entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_contained,
    output logic                          out_counted,
    output logic [wssc_pkg::SUM_W-1:0]    out_total
);

    logic [wssc_pkg::SUM_W-1:0] sum_reg;
    logic [wssc_pkg::SUM_W-1:0] sum_next;
    logic [wssc_pkg::SUM_W-1:0] sum_base;
    logic [wssc_pkg::SUM_W:0]   sum_wide;
    logic                       valid_reg;
    logic                       contained_reg;
    logic                       counted_reg;
    logic [wssc_pkg::SUM_W-1:0] total_reg;

    // Take an entry whenever the result register is free or draining.
    assign pop = !empty && (!valid_reg || out_ready);

    // Clear on database start, then saturating add of counted weights.
    always_comb
    begin
        sum_base = entry.db_start ? '0 : sum_reg;
        sum_wide = {1'b0, sum_base} + (wssc_pkg::SUM_W + 1)'(entry.weight);
        sum_next = sum_base;
        if (entry.seq_end && entry.counted)
        begin
            sum_next = sum_wide[wssc_pkg::SUM_W] ? '1 : sum_wide[wssc_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                sum_reg <= sum_next;
            end
            if (pop && entry.seq_end)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop && entry.seq_end)
        begin
            contained_reg <= entry.contained;
            counted_reg   <= entry.counted;
            total_reg     <= sum_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_contained = contained_reg;
    assign out_counted   = counted_reg;
    assign out_total     = total_reg;

endmodule
